@@ src/tmgpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmgpc_pkg
// Shared types and constants for the trimmed-mean gas ppm converter.
// ----------------------------------------------------------------------------
package tmgpc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ZERO_W   = 12;
  localparam int FS_W     = 13;
  localparam int CFG_W    = 13;
  localparam int SUM_W    = 15;
  localparam int TRIM_W   = 13;
  localparam int PPM_W    = 18;
  localparam int PROD_W   = SAMPLE_W + FS_W;      // avg * full scale
  localparam int DIFF_W   = PROD_W + 2;           // signed offset voltage, Q12 mV
  localparam int MAG_W    = PROD_W;
  localparam int SLOPE_W  = 8;
  localparam int NUM_W    = 22;                   // even, two quotient bits per step
  localparam int BURST_W  = 3;

  localparam int NUM_SEG  = 9;

  localparam logic [SAMPLE_W-1:0] ERR_CODE  = 12'd255;
  localparam logic [SAMPLE_W-1:0] CODE_MAX  = 12'd4095;
  localparam logic [16:0]         DIV5_MUL  = 17'd52429;  // 2^18 / 5, rounded up
  localparam int                  DIV5_SHR  = 18;
  localparam logic [PROD_W-1:0]   ZERO_RST  = 25'd700;
  localparam logic [FS_W-1:0]     FS_RST    = 13'd3774;
  localparam logic [BURST_W-1:0]  BURST_LAST = 3'd7;

  localparam int SEG_BOUND_MV [0:NUM_SEG] =
    '{0, 500, 750, 1000, 1150, 1600, 1850, 2100, 2200, 2450};
  localparam int SEG_SLOPE [0:NUM_SEG-1] =
    '{200, 100, 83, 75, 45, 40, 25, 10, 15};

  typedef enum logic {
    REG_ZERO_OFFSET = 1'b0,
    REG_FULL_SCALE  = 1'b1
  } reg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TRIM  = 8'b0000_0010,
    ST_AVG   = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_OFFS  = 8'b0001_0000,
    ST_NUMER = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic seed;
    logic accum;
    logic trim;
    logic avg;
    logic mul;
    logic offs;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

@@ src/trimmed_mean_gas_ppm_converter.sv @@
// ----------------------------------------------------------------------------
// trimmed_mean_gas_ppm_converter
// Trimmed-mean ADC averaging with piecewise-linear ppm calibration.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes one 12-bit sample word per
// handshake. Samples group into bursts of eight; the first word of a burst
// seeds max/min, the other seven are summed. Only the eighth word yields a
// result word on the output channel (out_valid_o/out_ready_i).
// While the non-final samples arrive, in_ready_o stays high. After the
// eighth sample the sequencer runs trim, average, scale, offset, numerator
// and slope divide steps (two quotient bits per divider cycle); in_ready_o
// stays low until the result word is loaded into the output register.
// The result sits in an output register: new samples are taken while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds in its last step until the register frees.
// Reset clears the burst count and state, drops out_valid_o and restores
// zero offset 700 mV and full scale 3774 mV. Configuration writes
// (cfg_we_i) take effect at once and belong between bursts.
// ----------------------------------------------------------------------------
module trimmed_mean_gas_ppm_converter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [tmgpc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [tmgpc_pkg::SAMPLE_W-1:0]        sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tmgpc_pkg::PPM_W-1:0]    ppm_q8_o,
  output logic [tmgpc_pkg::SAMPLE_W-1:0]        average_code_o,
  output logic                                  sum_error_o
);

  tmgpc_pkg::cmd_t cmd;
  tmgpc_pkg::sts_t sts;

  tmgpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tmgpc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .ppm_q8_o       (ppm_q8_o),
    .average_code_o (average_code_o),
    .sum_error_o    (sum_error_o)
  );

endmodule

@@ src/tmgpc_div.sv @@
// ----------------------------------------------------------------------------
// tmgpc_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tmgpc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [tmgpc_pkg::NUM_W-1:0]         num_i,
  input  logic [tmgpc_pkg::SLOPE_W-1:0]       den_i,
  output logic                                busy_o,
  output logic [tmgpc_pkg::NUM_W-1:0]         quo_o
);

  localparam int NW      = tmgpc_pkg::NUM_W;
  localparam int DW      = tmgpc_pkg::SLOPE_W;
  localparam int STEPS   = NW / 2;
  localparam int CNT_W   = $clog2(STEPS);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW-1:0]    num_q, num_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    den_q, den_d;

  logic [DW:0]      r1, r2;
  logic [DW-1:0]    rem1;
  logic             q1, q2;

  always_comb begin
    r1   = {rem_q, num_q[NW-1]};
    q1   = (r1 >= {1'b0, den_q});
    rem1 = q1 ? DW'(r1 - {1'b0, den_q}) : r1[DW-1:0];
    r2   = {rem1, num_q[NW-2]};
    q2   = (r2 >= {1'b0, den_q});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(STEPS - 1);
      num_d  = num_i;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      num_d = {num_q[NW-3:0], 2'b00};
      quo_d = {quo_q[NW-3:0], q1, q2};
      rem_d = q2 ? DW'(r2 - {1'b0, den_q}) : r2[DW-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

@@ src/tmgpc_dp.sv @@
// ----------------------------------------------------------------------------
// tmgpc_dp
// Datapath: burst max/min/sum, trimmed mean, mV scaling, segment lookup,
// slope divide and output register.
// ----------------------------------------------------------------------------
module tmgpc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tmgpc_pkg::cmd_t                       cmd_i,
  output tmgpc_pkg::sts_t                       sts_o,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [tmgpc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [tmgpc_pkg::SAMPLE_W-1:0]        sample_i,
  output logic signed [tmgpc_pkg::PPM_W-1:0]    ppm_q8_o,
  output logic [tmgpc_pkg::SAMPLE_W-1:0]        average_code_o,
  output logic                                  sum_error_o
);

  localparam int SW = tmgpc_pkg::SAMPLE_W;
  localparam int PW = tmgpc_pkg::PROD_W;
  localparam int XW = tmgpc_pkg::DIFF_W;
  localparam int MW = tmgpc_pkg::MAG_W;
  localparam int NW = tmgpc_pkg::NUM_W;
  localparam int LW = tmgpc_pkg::SLOPE_W;
  localparam int OW = tmgpc_pkg::PPM_W;
  localparam int P5W = tmgpc_pkg::SUM_W + 17;

  // config
  logic [tmgpc_pkg::ZERO_W-1:0] zero_q;
  logic [tmgpc_pkg::FS_W-1:0]   fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= tmgpc_pkg::ZERO_RST[tmgpc_pkg::ZERO_W-1:0];
      fs_q   <= tmgpc_pkg::FS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmgpc_pkg::REG_ZERO_OFFSET: zero_q <= cfg_data_i[tmgpc_pkg::ZERO_W-1:0];
        tmgpc_pkg::REG_FULL_SCALE:  fs_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // burst state
  logic [SW-1:0]                 max_q, min_q;
  logic [tmgpc_pkg::SUM_W-1:0]   sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      min_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.seed) begin
      max_q <= sample_i;
      min_q <= sample_i;
      sum_q <= '0;
    end else if (cmd_i.accum) begin
      if (sample_i >= max_q) max_q <= sample_i;
      if (sample_i <= min_q) min_q <= sample_i;
      sum_q <= sum_q + tmgpc_pkg::SUM_W'(sample_i);
    end
  end

  // trim and divide by five
  logic [tmgpc_pkg::TRIM_W-1:0] trim;
  logic [tmgpc_pkg::SUM_W-1:0]  diff;
  logic [P5W-1:0]               prod5_q;
  logic                         err_q;

  assign trim = tmgpc_pkg::TRIM_W'(max_q) + tmgpc_pkg::TRIM_W'(min_q);
  assign diff = sum_q - tmgpc_pkg::SUM_W'(trim);

  always_ff @(posedge clk_i) begin
    if (cmd_i.trim) begin
      err_q   <= (sum_q < tmgpc_pkg::SUM_W'(trim));
      prod5_q <= P5W'(diff) * P5W'(tmgpc_pkg::DIV5_MUL);
    end
  end

  logic [tmgpc_pkg::TRIM_W-1:0] q5;
  logic [SW-1:0]                avg_q;

  assign q5 = prod5_q[tmgpc_pkg::DIV5_SHR +: tmgpc_pkg::TRIM_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg) begin
      if (err_q) begin
        avg_q <= tmgpc_pkg::ERR_CODE;
      end else if (q5 > tmgpc_pkg::TRIM_W'(tmgpc_pkg::CODE_MAX)) begin
        avg_q <= tmgpc_pkg::CODE_MAX;
      end else begin
        avg_q <= q5[SW-1:0];
      end
    end
  end

  // scale to mV, Q12
  logic [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PW'(avg_q) * PW'(fs_q);
    end
  end

  // zero offset and segment lookup
  logic signed [XW-1:0] d;
  logic signed [XW-1:0] d_neg;
  logic [LW-1:0]        slope;

  assign d     = signed'(XW'(prod_q)) - signed'(XW'({zero_q, 12'b0}));
  assign d_neg = -d;

  always_comb begin
    logic found;
    logic signed [XW-1:0] lo, hi;
    found = 1'b0;
    slope = LW'(tmgpc_pkg::SEG_SLOPE[tmgpc_pkg::NUM_SEG-1]);
    for (int i = 0; i < tmgpc_pkg::NUM_SEG; i++) begin
      lo = signed'(XW'(tmgpc_pkg::SEG_BOUND_MV[i] * 4096));
      hi = signed'(XW'(tmgpc_pkg::SEG_BOUND_MV[i+1] * 4096));
      if (!found && (d > lo) && (d < hi)) begin
        slope = LW'(tmgpc_pkg::SEG_SLOPE[i]);
        found = 1'b1;
      end
    end
  end

  logic [MW-1:0] mag_q;
  logic [LW-1:0] slope_q;
  logic          neg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.offs) begin
      neg_q   <= d[XW-1];
      mag_q   <= d[XW-1] ? d_neg[MW-1:0] : d[MW-1:0];
      slope_q <= slope;
    end
  end

  // round: (mag + 8*slope) / (16*slope) == ((mag + 8*slope) >> 4) / slope
  logic [MW:0]   rnd;
  logic [NW-1:0] num;

  assign rnd = {1'b0, mag_q} + {(MW + 1 - LW - 3)'(0), slope_q, 3'b000};
  assign num = NW'(rnd[MW:4]);

  logic [NW-1:0] quo;
  logic          div_busy;

  tmgpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (slope_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign sts_o.div_busy = div_busy;

  // sign, saturate, output register
  logic [NW-1:0]         quo_neg;
  logic signed [OW-1:0]  ppm;

  assign quo_neg = ~quo + 1'b1;

  always_comb begin
    if (!neg_q) begin
      ppm = (quo > NW'(131071)) ? signed'(OW'(131071)) : signed'(quo[OW-1:0]);
    end else begin
      ppm = (quo > NW'(131072)) ? signed'({1'b1, (OW-1)'(0)}) : signed'(quo_neg[OW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ppm_q8_o       <= ppm;
      average_code_o <= avg_q;
      sum_error_o    <= err_q;
    end
  end

endmodule

@@ src/tmgpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmgpc_ctrl
// Controller: burst counting, conversion sequencing and output handshake.
// ----------------------------------------------------------------------------
module tmgpc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tmgpc_pkg::cmd_t cmd_o,
  input  tmgpc_pkg::sts_t sts_i
);

  tmgpc_pkg::state_e state_q, state_d;
  logic [tmgpc_pkg::BURST_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;

  assign in_ready_o = (state_q == tmgpc_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      tmgpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == '0) begin
            cmd_o.seed = 1'b1;
          end else begin
            cmd_o.accum = 1'b1;
            if (cnt_q == tmgpc_pkg::BURST_LAST) state_d = tmgpc_pkg::ST_TRIM;
          end
        end
      end
      tmgpc_pkg::ST_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d    = tmgpc_pkg::ST_AVG;
      end
      tmgpc_pkg::ST_AVG: begin
        cmd_o.avg = 1'b1;
        state_d   = tmgpc_pkg::ST_MUL;
      end
      tmgpc_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = tmgpc_pkg::ST_OFFS;
      end
      tmgpc_pkg::ST_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = tmgpc_pkg::ST_NUMER;
      end
      tmgpc_pkg::ST_NUMER: begin
        cmd_o.div_start = 1'b1;
        state_d         = tmgpc_pkg::ST_DIV;
      end
      tmgpc_pkg::ST_DIV: begin
        if (!sts_i.div_busy) state_d = tmgpc_pkg::ST_OUT;
      end
      tmgpc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = tmgpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tmgpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmgpc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ tb/tmgpc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tmgpc_checker
// Watches the converter's channels, predicts each burst's reading, compares.
// ----------------------------------------------------------------------------
// Tracks register writes and every accepted sample word, keeps its own burst
// state, and queues the reading that each eighth sample should produce.
// Every accepted result word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tmgpc_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [tmgpc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [tmgpc_pkg::SAMPLE_W-1:0]        sample_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic signed [tmgpc_pkg::PPM_W-1:0]    ppm_q8_i,
  input  logic [tmgpc_pkg::SAMPLE_W-1:0]        average_code_i,
  input  logic                                  sum_error_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  typedef struct packed {
    logic signed [tmgpc_pkg::PPM_W-1:0] ppm_q8;
    logic [tmgpc_pkg::SAMPLE_W-1:0]     average_code;
    logic                               sum_error;
  } gas_reading_t;

  localparam int KNEE_MV [0:tmgpc_pkg::NUM_SEG] =
    '{0, 500, 750, 1000, 1150, 1600, 1850, 2100, 2200, 2450};
  localparam int KNEE_SLOPE [0:tmgpc_pkg::NUM_SEG-1] =
    '{200, 100, 83, 75, 45, 40, 25, 10, 15};
  localparam int     TRIM_DIVISOR = 5;
  localparam longint PPM_HI       = 131071;
  localparam longint PPM_LO       = -131072;

  logic [tmgpc_pkg::ZERO_W-1:0]   zero_mv;
  logic [tmgpc_pkg::FS_W-1:0]     fs_mv;
  logic [tmgpc_pkg::BURST_W-1:0]  n_taken;
  logic [tmgpc_pkg::SAMPLE_W-1:0] hi_code;
  logic [tmgpc_pkg::SAMPLE_W-1:0] lo_code;
  logic [tmgpc_pkg::SUM_W-1:0]    acc;
  gas_reading_t                   readings_due [$];
  gas_reading_t                   want;
  int                             fail_count;
  int                             pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic logic signed [tmgpc_pkg::PPM_W-1:0] code_to_ppm_q8(
    logic [tmgpc_pkg::SAMPLE_W-1:0] code
  );
    longint offs_q12;
    longint mag;
    longint den;
    longint q;
    int     slope;
    bit     hit;
    offs_q12 = longint'(code) * longint'(fs_mv) - longint'(zero_mv) * 4096;
    slope    = KNEE_SLOPE[tmgpc_pkg::NUM_SEG-1];
    hit      = 1'b0;
    for (int i = 0; i < tmgpc_pkg::NUM_SEG; i++) begin
      if (!hit && longint'(KNEE_MV[i]) * 4096 < offs_q12 &&
          longint'(KNEE_MV[i+1]) * 4096 > offs_q12) begin
        slope = KNEE_SLOPE[i];
        hit   = 1'b1;
      end
    end
    den = 16 * slope;
    mag = (offs_q12 < 0) ? -offs_q12 : offs_q12;
    q   = (mag + den / 2) / den;
    if (offs_q12 < 0) q = -q;
    if (q > PPM_HI) q = PPM_HI;
    if (q < PPM_LO) q = PPM_LO;
    return q[tmgpc_pkg::PPM_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic take_sample(logic [tmgpc_pkg::SAMPLE_W-1:0] s);
    gas_reading_t r;
    int           trimmed;
    if (n_taken == '0) begin
      hi_code = s;
      lo_code = s;
      acc     = '0;
      n_taken = tmgpc_pkg::BURST_W'(1);
    end else begin
      if (s >= hi_code) hi_code = s;
      if (s <= lo_code) lo_code = s;
      acc = acc + tmgpc_pkg::SUM_W'(s);
      if (n_taken != tmgpc_pkg::BURST_LAST) begin
        n_taken++;
      end else begin
        n_taken = '0;
        trimmed = int'(acc) - int'(hi_code) - int'(lo_code);
        if (trimmed < 0) begin
          r.average_code = tmgpc_pkg::ERR_CODE;
          r.sum_error    = 1'b1;
        end else begin
          r.average_code = (trimmed / TRIM_DIVISOR > int'(tmgpc_pkg::CODE_MAX)) ?
                           tmgpc_pkg::CODE_MAX :
                           tmgpc_pkg::SAMPLE_W'(trimmed / TRIM_DIVISOR);
          r.sum_error    = 1'b0;
        end
        r.ppm_q8 = code_to_ppm_q8(r.average_code);
        readings_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_mv    = tmgpc_pkg::ZERO_W'(700);
      fs_mv      = tmgpc_pkg::FS_RST;
      n_taken    = '0;
      hi_code    = '0;
      lo_code    = '0;
      acc        = '0;
      fail_count = 0;
      readings_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (tmgpc_pkg::reg_idx_e'(cfg_idx_i))
          tmgpc_pkg::REG_ZERO_OFFSET: zero_mv = cfg_data_i[tmgpc_pkg::ZERO_W-1:0];
          tmgpc_pkg::REG_FULL_SCALE:  fs_mv   = cfg_data_i[tmgpc_pkg::FS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_sample(sample_i);
      if (out_valid_i && out_ready_i) begin
        if (readings_due.size() == 0) begin
          report_mismatch($sformatf("result word with no burst pending: ppm_q8=%0d avg=%0d",
                                    ppm_q8_i, average_code_i));
        end else begin
          want = readings_due.pop_front();
          if (ppm_q8_i !== want.ppm_q8)
            report_mismatch($sformatf("ppm_q8 got %0d want %0d", ppm_q8_i, want.ppm_q8));
          if (average_code_i !== want.average_code)
            report_mismatch($sformatf("average_code got %0d want %0d",
                                      average_code_i, want.average_code));
          if (sum_error_i !== want.sum_error)
            report_mismatch($sformatf("sum_error got %0b want %0b",
                                      sum_error_i, want.sum_error));
        end
      end
    end
    pending = readings_due.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the trimmed-mean gas ppm converter.
// ----------------------------------------------------------------------------
// Sends sample bursts: a few hand-picked ones, then random shaped bursts
// (flat at calibration knees, jittered, seed-high for the wrapped trim,
// seed-low for the clipped mean) under several register settings. The
// sender runs in bursts with random gaps; the receiver stalls on its own
// pattern and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_FLAT,
    SHAPE_JITTER,
    SHAPE_SEED_HIGH,
    SHAPE_SEED_LOW
  } burst_shape_e;

  localparam int KNEES_MV [0:9] =
    '{0, 500, 750, 1000, 1150, 1600, 1850, 2100, 2200, 2450};
  // -1 picks a random value for that register
  localparam int PH_ZERO [0:5] = '{0, 0, 4095, 4095, -1, 700};
  localparam int PH_FS   [0:5] = '{4096, 8191, 0, 8191, -1, 3774};
  localparam int BURSTS_PER_PHASE = 9;
  localparam int LONG_HOLD        = 300;
  localparam int SETTLE_CYCLES    = 20;

  logic                               clk_i;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_we_i    = 1'b0;
  logic                               cfg_idx_i   = 1'b0;
  logic [tmgpc_pkg::CFG_W-1:0]        cfg_data_i  = '0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic [tmgpc_pkg::SAMPLE_W-1:0]     sample_i    = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [tmgpc_pkg::PPM_W-1:0] ppm_q8_o;
  logic [tmgpc_pkg::SAMPLE_W-1:0]     average_code_o;
  logic                               sum_error_o;

  int fail_count;
  int pending;
  int run_left     = 0;
  int stall_req    = 0;
  int stall_served = 0;

  trimmed_mean_gas_ppm_converter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ppm_q8_o       (ppm_q8_o),
    .average_code_o (average_code_o),
    .sum_error_o    (sum_error_o)
  );

  tmgpc_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ppm_q8_i       (ppm_q8_o),
    .average_code_i (average_code_o),
    .sum_error_i    (sum_error_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: stretches of always-ready, coin-flip and mostly-stalled
  initial begin : rx_pattern
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_served != stall_req) begin
        stall_served = stall_req;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(4, 60);
        end
        left--;
        case (mode)
          0, 1:    out_ready_i <= 1'b1;
          2:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(tmgpc_pkg::reg_idx_e idx, logic [tmgpc_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(logic [tmgpc_pkg::SAMPLE_W-1:0] w);
    int gap;
    if (run_left == 0) begin
      run_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 8);
        default: gap = $urandom_range(9, 40);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    run_left--;
    in_valid_i <= 1'b1;
    sample_i   <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // word 0 is the seed
  task automatic send_words(logic [7:0][tmgpc_pkg::SAMPLE_W-1:0] w);
    for (int i = 0; i < 8; i++) send_word(w[i]);
  endtask

  function automatic logic [tmgpc_pkg::SAMPLE_W-1:0] clip_code(int v);
    if (v < 0) return '0;
    if (v > 4095) return tmgpc_pkg::CODE_MAX;
    return tmgpc_pkg::SAMPLE_W'(v);
  endfunction

  function automatic burst_shape_e pick_shape();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SHAPE_RANDOM;
    if (r < 55) return SHAPE_FLAT;
    if (r < 70) return SHAPE_JITTER;
    if (r < 85) return SHAPE_SEED_HIGH;
    return SHAPE_SEED_LOW;
  endfunction

  task automatic send_burst(burst_shape_e shape);
    logic [7:0][tmgpc_pkg::SAMPLE_W-1:0] w;
    int                                  base;
    case ($urandom_range(0, 3))
      0:       base = KNEES_MV[$urandom_range(0, 9)];
      1:       base = KNEES_MV[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      default: base = $urandom_range(0, 4095);
    endcase
    for (int i = 0; i < 8; i++) begin
      case (shape)
        SHAPE_FLAT:      w[i] = clip_code(base);
        SHAPE_JITTER:    w[i] = clip_code(base + $urandom_range(0, 100) - 50);
        SHAPE_SEED_HIGH: w[i] = (i == 0) ? clip_code($urandom_range(3000, 4095))
                                         : clip_code($urandom_range(0, 300));
        SHAPE_SEED_LOW:  w[i] = (i == 0) ? clip_code($urandom_range(0, 100))
                                         : clip_code($urandom_range(3800, 4095));
        default:         w[i] = clip_code($urandom_range(0, 4095));
      endcase
    end
    send_words(w);
  endtask

  // sender pauses until every reading is back, then lets the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // seed is the max: trimmed sum goes negative
    send_words({{7{12'h000}}, 12'hFFF});
    // seed is the min: mean clips at full code
    send_words({{7{12'hFFF}}, 12'h000});
    send_words({12'h2BC, 12'hFFE, 12'h800, 12'h001,
                12'h000, 12'hFFF, 12'h555, 12'hAAA});
    repeat (BURSTS_PER_PHASE) send_burst(pick_shape());

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(tmgpc_pkg::REG_ZERO_OFFSET,
                (PH_ZERO[p] < 0) ? tmgpc_pkg::CFG_W'($urandom_range(0, 8191))
                                 : tmgpc_pkg::CFG_W'(PH_ZERO[p]));
      write_reg(tmgpc_pkg::REG_FULL_SCALE,
                (PH_FS[p] < 0) ? tmgpc_pkg::CFG_W'($urandom_range(0, 8191))
                               : tmgpc_pkg::CFG_W'(PH_FS[p]));
      if (p == 1) stall_req++;
      repeat (BURSTS_PER_PHASE) send_burst(pick_shape());
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
